// ===== hdl/lab_pkg.sv =====
// Shared types and constants for the bitwise logarithm unit.
`default_nettype none
package lab_pkg;
    localparam logic [63:0] BASE_MIN   = 64'h0000_0001_1000_0000;
    localparam logic [63:0] BASE_RESET = 64'h0000_0002_0000_0000;
    localparam logic [8:0]  INT_MAX    = 9'd511;
    localparam logic [63:0] ONE_FIX    = 64'h0000_0001_0000_0000;

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RECIP   = 4'd1;
    localparam logic [3:0] ST_ICHK    = 4'd2;
    localparam logic [3:0] ST_ISQ     = 4'd3;
    localparam logic [3:0] ST_ISQCHK  = 4'd4;
    localparam logic [3:0] ST_IDIV    = 4'd5;
    localparam logic [3:0] ST_FSQ     = 4'd6;
    localparam logic [3:0] ST_FCHK    = 4'd7;
    localparam logic [3:0] ST_FDIV    = 4'd8;
    localparam logic [3:0] ST_OUT     = 4'd9;
    localparam logic [3:0] ST_MUL     = 4'd10;
    localparam logic [3:0] ST_DIV     = 4'd11;
endpackage
`default_nettype wire

// ===== hdl/log_any_base_bitwise_unit.sv =====
// Top level of the bitwise logarithm unit: sequencer, shared multiplier and divider.
//
// Usage: x_value words enter on x_valid/x_ready; results leave on out_valid/out_ready
// with fields error_zero, negative, int_part and frac_part. The base register is
// written on cfg_valid/cfg_ready with cfg_data and is taken only while idle.
// One word is worked on at a time; x_ready is high only when the unit is idle.
// A 64x64 square is built from four 32x32 partial products, one per cycle, and a
// 128/64 divide retires one quotient bit per cycle. An argument below one costs a
// reciprocal divide (the smallest argument skips it and saturates). Each fraction
// bit costs a square and, for a one bit, a divide; the integer search adds squares
// and a divide per power of the base taken out. A zero argument goes straight to
// the final state. The result sits in an output register until taken; a new word
// may be accepted meanwhile, and its result waits in the final state while
// out_valid is high and out_ready low. Reset sets the base to 2.0 and returns the
// sequencer to idle.
`default_nettype none
module log_any_base_bitwise_unit #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        x_valid,
    output logic             x_ready,
    input  wire logic [63:0] x_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             error_zero,
    output logic             negative,
    output logic [8:0]       int_part,
    output logic [31:0]      frac_part
);
    localparam int RW = $clog2(FRAC_BITS + 1);

    logic [3:0]   state_reg;
    logic [3:0]   ret_reg;     // state after a shared multiply or divide
    logic [63:0]  base_cfg_reg;
    logic [63:0]  b_reg;
    logic [63:0]  n_reg;
    logic [63:0]  pw_reg;
    logic [8:0]   k_reg;
    logic [8:0]   integ_reg;
    logic [31:0]  frac_reg;
    logic [RW-1:0] rnd_reg;
    logic         neg_reg;
    logic         err_reg;

    // Shared multiplier operands and accumulator.
    logic [63:0]  ma_reg, mb_reg;
    logic [127:0] prod_reg;
    logic [1:0]   mstep_reg;
    logic [63:0]  pa, pb;
    logic [31:0]  ma_sel, mb_sel;
    logic [63:0]  pp;

    // Shared restoring divider.
    logic [127:0] dnum_reg;
    logic [63:0]  dd_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  q_reg;
    logic [6:0]   dcnt_reg;
    logic [63:0]  rem_sh;
    logic         rem_carry;

    logic         out_valid_reg;
    logic         err_o_reg, neg_o_reg;
    logic [8:0]   int_o_reg;
    logic [31:0]  frac_o_reg;

    logic [127:0] n_up;
    logic [127:0] b_up;
    logic [9:0]   integ_sum;

    assign x_ready   = (state_reg == lab_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == lab_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign error_zero = err_o_reg;
    assign negative   = neg_o_reg;
    assign int_part   = int_o_reg;
    assign frac_part  = frac_o_reg;

    assign n_up = {32'd0, n_reg, 32'd0};
    assign b_up = {32'd0, b_reg, 32'd0};
    assign integ_sum = {1'b0, integ_reg} + {1'b0, k_reg};

    assign pa = ma_reg;
    assign pb = mb_reg;
    assign ma_sel = mstep_reg[1] ? pa[63:32] : pa[31:0];
    assign mb_sel = mstep_reg[0] ? pb[63:32] : pb[31:0];
    assign pp = {32'd0, ma_sel} * {32'd0, mb_sel};

    assign rem_carry = rem_reg[63];
    assign rem_sh = {rem_reg[62:0], dnum_reg[127]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lab_pkg::ST_IDLE;
            ret_reg       <= lab_pkg::ST_IDLE;
            base_cfg_reg  <= lab_pkg::BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The final state handles the output register itself.
            if (out_valid_reg && out_ready && state_reg != lab_pkg::ST_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                lab_pkg::ST_IDLE:
                begin
                    if (cfg_valid)
                        base_cfg_reg <= cfg_data;
                    if (x_valid && x_ready)
                    begin
                        b_reg     <= (base_cfg_reg < lab_pkg::BASE_MIN) ?
                                     lab_pkg::BASE_MIN : base_cfg_reg;
                        integ_reg <= '0;
                        frac_reg  <= '0;
                        rnd_reg   <= '0;
                        err_reg   <= (x_value == 64'd0);
                        if (x_value == 64'd0)
                        begin
                            neg_reg   <= 1'b0;
                            state_reg <= lab_pkg::ST_OUT;
                        end
                        else if (x_value < lab_pkg::ONE_FIX)
                        begin
                            neg_reg <= 1'b1;
                            if (x_value == 64'd1)
                            begin
                                n_reg     <= '1;
                                state_reg <= lab_pkg::ST_ICHK;
                            end
                            else
                            begin
                                dnum_reg  <= {64'd1, 64'd0};
                                dd_reg    <= x_value;
                                rem_reg   <= '0;
                                q_reg     <= '0;
                                dcnt_reg  <= '0;
                                ret_reg   <= lab_pkg::ST_RECIP;
                                state_reg <= lab_pkg::ST_DIV;
                            end
                        end
                        else
                        begin
                            neg_reg   <= 1'b0;
                            n_reg     <= x_value;
                            state_reg <= lab_pkg::ST_ICHK;
                        end
                    end
                end
                lab_pkg::ST_MUL:
                begin
                    // Partial products in order lo*lo, lo*hi, hi*lo, hi*hi.
                    prod_reg  <= prod_reg + ({64'd0, pp} << (32 * (32'(mstep_reg[1])
                                 + 32'(mstep_reg[0]))));
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd3)
                        state_reg <= ret_reg;
                end
                lab_pkg::ST_DIV:
                begin
                    dnum_reg <= {dnum_reg[126:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 7'd1;
                    if (rem_carry || rem_sh >= dd_reg)
                    begin
                        rem_reg <= rem_sh - dd_reg;
                        q_reg   <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[62:0], 1'b0};
                    end
                    if (dcnt_reg == 7'd127)
                        state_reg <= ret_reg;
                end
                lab_pkg::ST_RECIP:
                begin
                    n_reg     <= q_reg;
                    state_reg <= lab_pkg::ST_ICHK;
                end
                lab_pkg::ST_ICHK:
                begin
                    if (n_reg >= b_reg)
                    begin
                        pw_reg    <= b_reg;
                        k_reg     <= 9'd1;
                        ma_reg    <= b_reg;
                        mb_reg    <= b_reg;
                        prod_reg  <= '0;
                        mstep_reg <= '0;
                        ret_reg   <= lab_pkg::ST_ISQCHK;
                        state_reg <= lab_pkg::ST_MUL;
                    end
                    else
                        state_reg <= lab_pkg::ST_FSQ;
                end
                lab_pkg::ST_ISQCHK:
                begin
                    if (n_up >= prod_reg)
                    begin
                        pw_reg    <= prod_reg[95:32];
                        k_reg     <= {k_reg[7:0], 1'b0};
                        ma_reg    <= prod_reg[95:32];
                        mb_reg    <= prod_reg[95:32];
                        prod_reg  <= '0;
                        mstep_reg <= '0;
                        ret_reg   <= lab_pkg::ST_ISQCHK;
                        state_reg <= lab_pkg::ST_MUL;
                    end
                    else
                    begin
                        dnum_reg  <= n_up;
                        dd_reg    <= pw_reg;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        dcnt_reg  <= '0;
                        ret_reg   <= lab_pkg::ST_IDIV;
                        state_reg <= lab_pkg::ST_DIV;
                    end
                end
                lab_pkg::ST_IDIV:
                begin
                    n_reg     <= q_reg;
                    integ_reg <= (integ_sum > {1'b0, lab_pkg::INT_MAX}) ?
                                 lab_pkg::INT_MAX : integ_sum[8:0];
                    state_reg <= lab_pkg::ST_ICHK;
                end
                lab_pkg::ST_FSQ:
                begin
                    if (rnd_reg == RW'(FRAC_BITS))
                        state_reg <= lab_pkg::ST_OUT;
                    else
                    begin
                        ma_reg    <= n_reg;
                        mb_reg    <= n_reg;
                        prod_reg  <= '0;
                        mstep_reg <= '0;
                        ret_reg   <= lab_pkg::ST_FCHK;
                        state_reg <= lab_pkg::ST_MUL;
                    end
                end
                lab_pkg::ST_FCHK:
                begin
                    rnd_reg <= rnd_reg + RW'(1);
                    if (prod_reg >= b_up)
                    begin
                        frac_reg  <= {frac_reg[30:0], 1'b1};
                        dnum_reg  <= prod_reg;
                        dd_reg    <= b_reg;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        dcnt_reg  <= '0;
                        ret_reg   <= lab_pkg::ST_FDIV;
                        state_reg <= lab_pkg::ST_DIV;
                    end
                    else
                    begin
                        frac_reg  <= {frac_reg[30:0], 1'b0};
                        n_reg     <= prod_reg[95:32];
                        state_reg <= lab_pkg::ST_FSQ;
                    end
                end
                lab_pkg::ST_FDIV:
                begin
                    n_reg     <= q_reg;
                    state_reg <= lab_pkg::ST_FSQ;
                end
                lab_pkg::ST_OUT:
                begin
                    // Wait here while the previous result is still unclaimed.
                    if (!out_valid_reg || out_ready)
                    begin
                        err_o_reg     <= err_reg;
                        neg_o_reg     <= neg_reg;
                        int_o_reg     <= integ_reg;
                        frac_o_reg    <= frac_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= lab_pkg::ST_IDLE;
                    end
                end
                default:
                    state_reg <= lab_pkg::ST_IDLE;
            endcase
        end
    end

    a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(error_zero) && $stable(negative))
        else $error("result flags changed while stalled");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frac_part) && $stable(int_part))
        else $error("result changed while stalled");
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_zero |-> !negative && int_part == 9'd0 && frac_part == 32'd0)
        else $error("zero argument result not clean");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> state_reg == lab_pkg::ST_IDLE)
        else $error("base write outside idle");
endmodule
`default_nettype wire
